// File: design/tteg_pkg.sv
// ----------------------------------------------------------------------------
// tteg_pkg
// Shared types and constants of the triggered envelope gate: envelope format,
// phase and trigger codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package tteg_pkg;

  // Bits per digit of the serial multiplier
  localparam int unsigned DIGIT_BITS = 4;

  // Envelope level format: unsigned Q1.23
  localparam int unsigned ENV_BITS = 24;
  localparam int unsigned ENV_FRAC = 23;
  localparam logic [ENV_BITS-1:0] ENV_ONE   = 24'd8388608;
  localparam logic [ENV_BITS-1:0] ENV_PEAK  = 24'd8304722;
  localparam logic [ENV_BITS-1:0] ENV_FLOOR = 24'd8388;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RETRIGGER = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNELS  = 3'd5;

  // Register reset values, given at their default binary point
  localparam longint unsigned THRESH_RST_BASE = 64'd703687441776;
  localparam int unsigned     THRESH_RST_FRAC = 46;
  localparam longint unsigned ATTACK_RST_BASE = 64'd142;
  localparam longint unsigned DECAY_RST_BASE  = 64'd3;
  localparam int unsigned     COEFF_RST_FRAC  = 16;

  // Trigger source codes
  localparam logic [1:0] TRIG_AUDIO  = 2'd0;
  localparam logic [1:0] TRIG_NOTE   = 2'd1;
  localparam logic [1:0] TRIG_EITHER = 2'd2;

  // Note event codes
  localparam logic [1:0] NOTE_ON  = 2'd1;
  localparam logic [1:0] NOTE_OFF = 2'd2;

  // Channel count codes
  localparam logic [1:0] CH_MONO   = 2'd1;
  localparam logic [1:0] CH_STEREO = 2'd2;

  // Envelope phase, held one-hot
  typedef enum logic [2:0] {
    EP_IDLE   = 3'b001,
    EP_ATTACK = 3'b010,
    EP_DECAY  = 3'b100
  } env_phase_t;

  // Phase code as shown on the result channel
  typedef enum logic [1:0] {
    PHASE_IDLE   = 2'd0,
    PHASE_ATTACK = 2'd1,
    PHASE_DECAY  = 2'd2
  } phase_code_t;

  // Status of the serial multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  function automatic phase_code_t phase_code(input env_phase_t ph);
    phase_code_t code;
    unique case (ph)
      EP_ATTACK: code = PHASE_ATTACK;
      EP_DECAY:  code = PHASE_DECAY;
      default:   code = PHASE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: design/tteg_cfg_regs.sv
// ----------------------------------------------------------------------------
// tteg_cfg_regs
// Configuration register file: decodes the write port into the threshold,
// the coefficients and the mode registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tteg_cfg_regs #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned COEFF_BITS  = 16,
  localparam int unsigned THRESH_BITS = 2 * SAMPLE_BITS - 1,
  localparam int unsigned CFG_BITS    = (THRESH_BITS > COEFF_BITS) ? THRESH_BITS : COEFF_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [tteg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_BITS-1:0]                  cfg_data,
  output logic      [THRESH_BITS-1:0]               threshold,
  output logic      [COEFF_BITS-1:0]                attack_coeff,
  output logic      [COEFF_BITS-1:0]                decay_coeff,
  output logic                                      retrigger_en,
  output logic      [1:0]                           trigger_mode,
  output logic      [1:0]                           channel_count
);

  // Rescale the reset values to the configured binary points
  localparam int unsigned THRESH_FRAC = 2 * SAMPLE_BITS - 2;
  localparam longint unsigned THRESH_RST =
    (THRESH_FRAC >= tteg_pkg::THRESH_RST_FRAC) ?
      (tteg_pkg::THRESH_RST_BASE << (THRESH_FRAC - tteg_pkg::THRESH_RST_FRAC)) :
      (tteg_pkg::THRESH_RST_BASE >> (tteg_pkg::THRESH_RST_FRAC - THRESH_FRAC));
  localparam longint unsigned ATTACK_RST =
    (COEFF_BITS >= tteg_pkg::COEFF_RST_FRAC) ?
      (tteg_pkg::ATTACK_RST_BASE << (COEFF_BITS - tteg_pkg::COEFF_RST_FRAC)) :
      (tteg_pkg::ATTACK_RST_BASE >> (tteg_pkg::COEFF_RST_FRAC - COEFF_BITS));
  localparam longint unsigned DECAY_RST =
    (COEFF_BITS >= tteg_pkg::COEFF_RST_FRAC) ?
      (tteg_pkg::DECAY_RST_BASE << (COEFF_BITS - tteg_pkg::COEFF_RST_FRAC)) :
      (tteg_pkg::DECAY_RST_BASE >> (tteg_pkg::COEFF_RST_FRAC - COEFF_BITS));

  logic [THRESH_BITS-1:0] thresh_r,  thresh_nxt;
  logic [COEFF_BITS-1:0]  attack_r,  attack_nxt;
  logic [COEFF_BITS-1:0]  decay_r,   decay_nxt;
  logic                   retrig_r,  retrig_nxt;
  logic [1:0]             mode_r,    mode_nxt;
  logic [1:0]             chans_r,   chans_nxt;

  // Decode a write; unknown indexes drop
  always_comb begin
    thresh_nxt = thresh_r;
    attack_nxt = attack_r;
    decay_nxt  = decay_r;
    retrig_nxt = retrig_r;
    mode_nxt   = mode_r;
    chans_nxt  = chans_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        tteg_pkg::REG_THRESHOLD: thresh_nxt = cfg_data[THRESH_BITS-1:0];
        tteg_pkg::REG_ATTACK:    attack_nxt = cfg_data[COEFF_BITS-1:0];
        tteg_pkg::REG_DECAY:     decay_nxt  = cfg_data[COEFF_BITS-1:0];
        tteg_pkg::REG_RETRIGGER: retrig_nxt = cfg_data[0];
        tteg_pkg::REG_MODE:      mode_nxt   = cfg_data[1:0];
        tteg_pkg::REG_CHANNELS:  chans_nxt  = cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_BITS'(THRESH_RST);
      attack_r <= COEFF_BITS'(ATTACK_RST);
      decay_r  <= COEFF_BITS'(DECAY_RST);
      retrig_r <= 1'b1;
      mode_r   <= tteg_pkg::TRIG_AUDIO;
      chans_r  <= tteg_pkg::CH_STEREO;
    end else begin
      thresh_r <= thresh_nxt;
      attack_r <= attack_nxt;
      decay_r  <= decay_nxt;
      retrig_r <= retrig_nxt;
      mode_r   <= mode_nxt;
      chans_r  <= chans_nxt;
    end
  end

  assign threshold     = thresh_r;
  assign attack_coeff  = attack_r;
  assign decay_coeff   = decay_r;
  assign retrigger_en  = retrig_r;
  assign trigger_mode  = mode_r;
  assign channel_count = chans_r;

endmodule

`default_nettype wire

// File: design/tteg_serial_mul.sv
// ----------------------------------------------------------------------------
// tteg_serial_mul
// Digit-serial unsigned multiplier: the multiplier operand shifts out of the
// low end of the product register one digit per cycle while partial products
// accumulate into the high end.
// ----------------------------------------------------------------------------
`default_nettype none

module tteg_serial_mul #(
  parameter int unsigned A_BITS = 24,
  localparam int unsigned NUM_DIGITS =
    (A_BITS + tteg_pkg::DIGIT_BITS - 1) / tteg_pkg::DIGIT_BITS,
  localparam int unsigned PROD_BITS = A_BITS + NUM_DIGITS * tteg_pkg::DIGIT_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [A_BITS-1:0]          a,
  input  wire logic [A_BITS-1:0]          b,
  output tteg_pkg::mul_stat_t             stat,
  output logic      [PROD_BITS-1:0]       product
);

  localparam int unsigned DW       = tteg_pkg::DIGIT_BITS;
  localparam int unsigned B_EXT    = NUM_DIGITS * DW;
  localparam int unsigned SUM_BITS = A_BITS + DW;
  localparam int unsigned CNT_BITS = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(NUM_DIGITS - 1);

  logic [A_BITS-1:0]    a_r,    a_nxt;
  logic [PROD_BITS-1:0] prod_r, prod_nxt;
  logic [CNT_BITS-1:0]  cnt_r,  cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [SUM_BITS-1:0]  step_sum;

  // Add multiplicand times the low digit to the upper half
  assign step_sum = SUM_BITS'(prod_r[PROD_BITS-1 -: A_BITS]) +
                    SUM_BITS'(a_r) * SUM_BITS'(prod_r[DW-1:0]);

  always_comb begin
    a_nxt    = a_r;
    prod_nxt = prod_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      // Advance one digit
      prod_nxt = {step_sum, prod_r[B_EXT-1:DW]};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        cnt_nxt  = '0;
      end
    end else if (start) begin
      // Load operands; multiplier sits in the low end
      a_nxt    = a;
      prod_nxt = PROD_BITS'(b);
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r    <= a_nxt;
    prod_r <= prod_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = prod_r;

endmodule

`default_nettype wire

// File: design/threshold_triggered_envelope_gate_top.sv
// One request carries a stereo (or mono) frame and a note event; the block
// answers with the frame scaled by an attack/decay envelope, the envelope level
// (unsigned Q1.23) and the phase after the step. Frames are handled one at a
// time by a sequencer around a single multiplier that takes 4 bits of its
// operand per cycle. A stereo frame with the envelope active needs five
// products; mono drops two products and an idle envelope drops one. The next
// request is taken while a finished result still waits in the output register.
// ----------------------------------------------------------------------------
// threshold_triggered_envelope_gate_top
// Threshold-triggered attack/decay envelope gate: mean-square trigger, note
// trigger, one-pole envelope and gain stage around a digit-serial multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module threshold_triggered_envelope_gate_top #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned COEFF_BITS  = 16,
  localparam int unsigned THRESH_BITS = 2 * SAMPLE_BITS - 1,
  localparam int unsigned CFG_BITS    = (THRESH_BITS > COEFF_BITS) ? THRESH_BITS : COEFF_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Configuration
  input  wire logic                                 cfg_wr_en,
  input  wire logic [tteg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_BITS-1:0]                  cfg_data,
  // Input requests
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_left_sample,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_right_sample,
  input  wire logic [1:0]                           in_note_event,
  // Result requests
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]             out_left_out,
  output logic signed [SAMPLE_BITS-1:0]             out_right_out,
  output logic [tteg_pkg::ENV_BITS-1:0]             out_envelope_out,
  output logic [1:0]                                out_phase_out
);

  localparam int unsigned EB      = tteg_pkg::ENV_BITS;
  localparam int unsigned MUL_W   = (SAMPLE_BITS > EB) ? SAMPLE_BITS : EB;
  localparam int unsigned MUL_ND  = (MUL_W + tteg_pkg::DIGIT_BITS - 1) / tteg_pkg::DIGIT_BITS;
  localparam int unsigned PROD_W  = MUL_W + MUL_ND * tteg_pkg::DIGIT_BITS;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_SQL  = 9'b000000010,
    ST_SQR  = 9'b000000100,
    ST_TRIG = 9'b000001000,
    ST_ENV  = 9'b000010000,
    ST_UPD  = 9'b000100000,
    ST_SCL  = 9'b001000000,
    ST_SCR  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } seq_state_t;

  // Configuration
  logic [THRESH_BITS-1:0] thresh;
  logic [COEFF_BITS-1:0]  attack_coeff;
  logic [COEFF_BITS-1:0]  decay_coeff;
  logic                   retrig_en;
  logic [1:0]             trig_mode;
  logic [1:0]             chan_cnt;
  logic                   mono;

  tteg_cfg_regs #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEFF_BITS  (COEFF_BITS)
  ) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .threshold     (thresh),
    .attack_coeff  (attack_coeff),
    .decay_coeff   (decay_coeff),
    .retrigger_en  (retrig_en),
    .trigger_mode  (trig_mode),
    .channel_count (chan_cnt)
  );

  assign mono = (chan_cnt == tteg_pkg::CH_MONO);

  // Shared multiplier
  logic                 mul_start;
  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  tteg_pkg::mul_stat_t  mul_stat;
  logic [PROD_W-1:0]    mul_prod;
  logic                 mul_go;

  tteg_serial_mul #(
    .A_BITS (MUL_W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .stat    (mul_stat),
    .product (mul_prod)
  );

  assign mul_go = !mul_stat.busy && !mul_stat.done;

  // Sequencer and datapath registers
  seq_state_t            state_r,      state_nxt;
  logic [SAMPLE_BITS-1:0] lmag_r,      lmag_nxt;
  logic [SAMPLE_BITS-1:0] rmag_r,      rmag_nxt;
  logic                   lneg_r,      lneg_nxt;
  logic                   rneg_r,      rneg_nxt;
  logic                   note_held_r, note_held_nxt;
  logic                   prev_aud_r,  prev_aud_nxt;
  logic                   prev_note_r, prev_note_nxt;
  logic [THRESH_BITS-1:0] sq_l_r,      sq_l_nxt;
  logic [THRESH_BITS-1:0] sq_r_r,      sq_r_nxt;
  logic                   should_r,    should_nxt;
  logic                   edge_r,      edge_nxt;
  tteg_pkg::env_phase_t   work_ph_r,   work_ph_nxt;
  tteg_pkg::env_phase_t   phase_r,     phase_nxt;
  logic [EB-1:0]          level_r,     level_nxt;
  logic [EB-1:0]          env_q_r,     env_q_nxt;
  logic                   sticky_r,    sticky_nxt;
  logic [SAMPLE_BITS-1:0] res_l_r,     res_l_nxt;
  logic [SAMPLE_BITS-1:0] res_r_r,     res_r_nxt;
  logic                   out_vld_r,   out_vld_nxt;
  logic [SAMPLE_BITS-1:0] out_l_r,     out_l_nxt;
  logic [SAMPLE_BITS-1:0] out_rr_r,    out_rr_nxt;
  logic [EB-1:0]          out_env_r,   out_env_nxt;
  logic [1:0]             out_ph_r,    out_ph_nxt;

  // Sample magnitudes at the input
  logic [SAMPLE_BITS-1:0] in_l_raw, in_r_raw, in_l_mag, in_r_mag;
  assign in_l_raw = in_left_sample;
  assign in_r_raw = in_right_sample;
  assign in_l_mag = in_l_raw[SAMPLE_BITS-1] ? (~in_l_raw + 1'b1) : in_l_raw;
  assign in_r_mag = in_r_raw[SAMPLE_BITS-1] ? (~in_r_raw + 1'b1) : in_r_raw;

  // Mean square against the threshold, and trigger selection
  logic [THRESH_BITS:0]   sq_sum;
  logic [THRESH_BITS-1:0] mean_sq;
  logic                   audio_trig, should, was, trig_edge;
  tteg_pkg::env_phase_t   ph_mid;

  assign sq_sum  = {1'b0, sq_l_r} + {1'b0, sq_r_r};
  assign mean_sq = mono ? sq_l_r : sq_sum[THRESH_BITS:1];
  assign audio_trig = (mean_sq >= thresh);

  always_comb begin
    unique case (trig_mode)
      tteg_pkg::TRIG_AUDIO: begin
        should = audio_trig;
        was    = prev_aud_r;
      end
      tteg_pkg::TRIG_NOTE: begin
        should = note_held_r;
        was    = prev_note_r;
      end
      tteg_pkg::TRIG_EITHER: begin
        should = audio_trig || note_held_r;
        was    = prev_aud_r || prev_note_r;
      end
      default: begin
        should = 1'b0;
        was    = 1'b0;
      end
    endcase
  end

  assign trig_edge = should && !was;
  assign ph_mid = (trig_edge && (phase_r != tteg_pkg::EP_DECAY)) ? tteg_pkg::EP_ATTACK : phase_r;

  // Envelope step arithmetic
  logic [EB-1:0] env_gap;
  logic [EB:0]   atk_sum;
  logic [EB:0]   dcy_dec;
  logic [EB-1:0] dcy_lvl;

  assign env_gap = tteg_pkg::ENV_ONE - level_r;
  assign atk_sum = {1'b0, level_r} + {1'b0, env_q_r};
  assign dcy_dec = {1'b0, env_q_r} + {{EB{1'b0}}, sticky_r};
  assign dcy_lvl = (dcy_dec > {1'b0, level_r}) ? '0 : (level_r - dcy_dec[EB-1:0]);

  // Scaled sample magnitude, before its sign is put back
  logic [SAMPLE_BITS-1:0] scaled;
  assign scaled = mul_prod[tteg_pkg::ENV_FRAC +: SAMPLE_BITS];

  always_comb begin
    state_nxt     = state_r;
    lmag_nxt      = lmag_r;
    rmag_nxt      = rmag_r;
    lneg_nxt      = lneg_r;
    rneg_nxt      = rneg_r;
    note_held_nxt = note_held_r;
    prev_aud_nxt  = prev_aud_r;
    prev_note_nxt = prev_note_r;
    sq_l_nxt      = sq_l_r;
    sq_r_nxt      = sq_r_r;
    should_nxt    = should_r;
    edge_nxt      = edge_r;
    work_ph_nxt   = work_ph_r;
    phase_nxt     = phase_r;
    level_nxt     = level_r;
    env_q_nxt     = env_q_r;
    sticky_nxt    = sticky_r;
    res_l_nxt     = res_l_r;
    res_r_nxt     = res_r_r;
    out_vld_nxt   = out_vld_r;
    out_l_nxt     = out_l_r;
    out_rr_nxt    = out_rr_r;
    out_env_nxt   = out_env_r;
    out_ph_nxt    = out_ph_r;
    mul_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;

    // Drop a result once taken
    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        // Capture the request and track the held note
        if (in_valid) begin
          lmag_nxt = in_l_mag;
          rmag_nxt = in_r_mag;
          lneg_nxt = in_l_raw[SAMPLE_BITS-1];
          rneg_nxt = in_r_raw[SAMPLE_BITS-1];
          if (in_note_event == tteg_pkg::NOTE_ON) begin
            note_held_nxt = 1'b1;
          end else if (in_note_event == tteg_pkg::NOTE_OFF) begin
            note_held_nxt = 1'b0;
          end
          state_nxt = ST_SQL;
        end
      end
      ST_SQL: begin
        mul_a     = MUL_W'(lmag_r);
        mul_b     = MUL_W'(lmag_r);
        mul_start = mul_go;
        if (mul_stat.done) begin
          sq_l_nxt  = mul_prod[THRESH_BITS-1:0];
          state_nxt = mono ? ST_TRIG : ST_SQR;
        end
      end
      ST_SQR: begin
        mul_a     = MUL_W'(rmag_r);
        mul_b     = MUL_W'(rmag_r);
        mul_start = mul_go;
        if (mul_stat.done) begin
          sq_r_nxt  = mul_prod[THRESH_BITS-1:0];
          state_nxt = ST_TRIG;
        end
      end
      ST_TRIG: begin
        // Decide the step and remember this frame's triggers
        should_nxt    = should;
        edge_nxt      = trig_edge;
        work_ph_nxt   = ph_mid;
        prev_aud_nxt  = audio_trig;
        prev_note_nxt = note_held_r;
        state_nxt     = (ph_mid == tteg_pkg::EP_IDLE) ? ST_UPD : ST_ENV;
      end
      ST_ENV: begin
        if (work_ph_r == tteg_pkg::EP_ATTACK) begin
          mul_a = MUL_W'(env_gap);
          mul_b = MUL_W'(attack_coeff);
        end else begin
          mul_a = MUL_W'(level_r);
          mul_b = MUL_W'(decay_coeff);
        end
        mul_start = mul_go;
        if (mul_stat.done) begin
          env_q_nxt  = mul_prod[COEFF_BITS +: EB];
          sticky_nxt = |mul_prod[COEFF_BITS-1:0];
          state_nxt  = ST_UPD;
        end
      end
      ST_UPD: begin
        // Apply the one-pole step and move the phase
        unique case (work_ph_r)
          tteg_pkg::EP_ATTACK: begin
            level_nxt = atk_sum[EB-1:0];
            phase_nxt = ((atk_sum[EB-1:0] >= tteg_pkg::ENV_PEAK) || !should_r) ?
                        tteg_pkg::EP_DECAY : tteg_pkg::EP_ATTACK;
          end
          tteg_pkg::EP_DECAY: begin
            if (dcy_lvl <= tteg_pkg::ENV_FLOOR) begin
              level_nxt = '0;
              phase_nxt = tteg_pkg::EP_IDLE;
            end else begin
              level_nxt = dcy_lvl;
              phase_nxt = tteg_pkg::EP_DECAY;
            end
            if (retrig_en && edge_r) begin
              phase_nxt = tteg_pkg::EP_ATTACK;
            end
          end
          default: begin
            level_nxt = '0;
            phase_nxt = tteg_pkg::EP_IDLE;
          end
        endcase
        state_nxt = ST_SCL;
      end
      ST_SCL: begin
        mul_a     = MUL_W'(lmag_r);
        mul_b     = MUL_W'(level_r);
        mul_start = mul_go;
        if (mul_stat.done) begin
          res_l_nxt = lneg_r ? (~scaled + 1'b1) : scaled;
          if (mono) begin
            res_r_nxt = '0;
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_SCR;
          end
        end
      end
      ST_SCR: begin
        mul_a     = MUL_W'(rmag_r);
        mul_b     = MUL_W'(level_r);
        mul_start = mul_go;
        if (mul_stat.done) begin
          res_r_nxt = rneg_r ? (~scaled + 1'b1) : scaled;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // Hand the result over once the output register is free
        if (!out_vld_r || out_ready) begin
          out_vld_nxt = 1'b1;
          out_l_nxt   = res_l_r;
          out_rr_nxt  = res_r_r;
          out_env_nxt = level_r;
          out_ph_nxt  = tteg_pkg::phase_code(phase_r);
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      note_held_r <= 1'b0;
      prev_aud_r  <= 1'b0;
      prev_note_r <= 1'b0;
      phase_r     <= tteg_pkg::EP_IDLE;
      level_r     <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      note_held_r <= note_held_nxt;
      prev_aud_r  <= prev_aud_nxt;
      prev_note_r <= prev_note_nxt;
      phase_r     <= phase_nxt;
      level_r     <= level_nxt;
      out_vld_r   <= out_vld_nxt;
    end
    lmag_r    <= lmag_nxt;
    rmag_r    <= rmag_nxt;
    lneg_r    <= lneg_nxt;
    rneg_r    <= rneg_nxt;
    sq_l_r    <= sq_l_nxt;
    sq_r_r    <= sq_r_nxt;
    should_r  <= should_nxt;
    edge_r    <= edge_nxt;
    work_ph_r <= work_ph_nxt;
    env_q_r   <= env_q_nxt;
    sticky_r  <= sticky_nxt;
    res_l_r   <= res_l_nxt;
    res_r_r   <= res_r_nxt;
    out_l_r   <= out_l_nxt;
    out_rr_r  <= out_rr_nxt;
    out_env_r <= out_env_nxt;
    out_ph_r  <= out_ph_nxt;
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_vld_r;
  assign out_left_out     = $signed(out_l_r);
  assign out_right_out    = $signed(out_rr_r);
  assign out_envelope_out = out_env_r;
  assign out_phase_out    = out_ph_r;

endmodule

`default_nettype wire

// File: design/tteg_checker.sv
// ----------------------------------------------------------------------------
// tteg_checker
// Port-level checks of the envelope gate: result hold under stall, envelope
// range, idle and zero-gain consistency, and one frame at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module tteg_checker #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [SAMPLE_BITS-1:0]     out_left_out,
  input wire logic signed [SAMPLE_BITS-1:0]     out_right_out,
  input wire logic [tteg_pkg::ENV_BITS-1:0]     out_envelope_out,
  input wire logic [1:0]                        out_phase_out
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_out) &&
      $stable(out_right_out) && $stable(out_envelope_out) && $stable(out_phase_out))
    else $error("stalled result changed");

  // Envelope never exceeds unity gain
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_envelope_out <= tteg_pkg::ENV_ONE)
    else $error("envelope above 1.0");

  // Idle phase carries a zero envelope
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_phase_out == tteg_pkg::PHASE_IDLE) |-> out_envelope_out == '0)
    else $error("idle phase with nonzero envelope");

  // Zero gain silences both channels
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_envelope_out == '0) |-> (out_left_out == '0) && (out_right_out == '0))
    else $error("output nonzero at zero gain");

  // A frame in work blocks the next request
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a frame is in work");

endmodule

bind threshold_triggered_envelope_gate_top tteg_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_tteg_checker (.*);

`default_nettype wire

// File: test/threshold_triggered_envelope_gate_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_triggered_envelope_gate_top_tb
// Self-checking bench for the triggered envelope gate. A directed table walks
// the sample extremes, every trigger mode, note codes and channel counts, and
// each register at its limits. Random phases follow, built from loud bursts
// over a quiet floor, under several register settings and idle patterns.
// Every frame is scored against a cycle-free envelope predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module threshold_triggered_envelope_gate_top_tb;

  localparam int unsigned SW = 24;
  localparam int unsigned CW = 16;
  localparam int unsigned CFG_W = 2 * SW - 1;
  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned FRAMES_PER_PHASE = 66;
  localparam longint unsigned CYCLE_LIMIT = 300000;

  typedef logic signed [SW-1:0] sample_t;

  localparam sample_t S_MAX = 24'sh7FFFFF;
  localparam sample_t S_MIN = 24'sh800000;

  localparam longint unsigned LEVEL_ONE = 64'd1 << 23;
  localparam longint unsigned THR_FULL = 64'd1 << 46;
  localparam longint unsigned THR_RESET = 64'd703687441776;
  localparam longint unsigned ATTACK_RESET = 64'd142;
  localparam longint unsigned DECAY_RESET = 64'd3;
  localparam longint unsigned COEFF_MAX = 64'd65535;

  localparam logic [1:0] NOTE_NONE = 2'd0;
  localparam logic [1:0] NOTE_RSVD = 2'd3;
  localparam logic [1:0] TRIG_NONE = 2'd3;
  localparam logic [1:0] CH_UNUSED0 = 2'd0;
  localparam logic [1:0] CH_UNUSED3 = 2'd3;

  typedef struct packed {
    sample_t               left;
    sample_t               right;
    logic [23:0]           env;
    tteg_pkg::phase_code_t phase;
  } gate_result_t;

  typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t       kind;
    logic [2:0]      idx;
    longint unsigned val;
    sample_t         left;
    sample_t         right;
    logic [1:0]      note;
    logic            silent;
  } stim_row_t;

  localparam int unsigned DIRECTED_ROWS = 38;

  // Silent rows must come out as zero samples, zero level, idle
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, 0, 0, NOTE_NONE, 1'b1},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, S_MAX, S_MIN, NOTE_NONE, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, S_MIN, S_MIN, tteg_pkg::NOTE_ON, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, 0, 0, tteg_pkg::NOTE_OFF, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, 0, 0, NOTE_RSVD, 1'b0},
    '{ROW_CFG, tteg_pkg::REG_MODE, tteg_pkg::TRIG_NOTE, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, 1, -1, tteg_pkg::NOTE_ON, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_CFG, tteg_pkg::REG_RETRIGGER, 0, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, 0, 0, tteg_pkg::NOTE_OFF, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, 0, 0, tteg_pkg::NOTE_ON, 1'b0},
    '{ROW_CFG, tteg_pkg::REG_ATTACK, COEFF_MAX, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_CFG, tteg_pkg::REG_DECAY, COEFF_MAX, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_CFG, tteg_pkg::REG_THRESHOLD, THR_FULL, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_CFG, tteg_pkg::REG_MODE, tteg_pkg::TRIG_EITHER, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, S_MIN, S_MIN, tteg_pkg::NOTE_OFF, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, S_MIN, S_MIN, NOTE_NONE, 1'b0},
    '{ROW_CFG, tteg_pkg::REG_CHANNELS, tteg_pkg::CH_MONO, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, S_MIN, 12345, tteg_pkg::NOTE_ON, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, S_MAX, S_MIN, NOTE_NONE, 1'b0},
    '{ROW_CFG, tteg_pkg::REG_CHANNELS, CH_UNUSED0, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, 4194304, -4194304, NOTE_NONE, 1'b0},
    '{ROW_CFG, tteg_pkg::REG_CHANNELS, CH_UNUSED3, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, S_MAX, S_MAX, tteg_pkg::NOTE_OFF, 1'b0},
    '{ROW_CFG, tteg_pkg::REG_THRESHOLD, 0, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_CFG, tteg_pkg::REG_ATTACK, 1, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_CFG, tteg_pkg::REG_DECAY, 1, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_CFG, tteg_pkg::REG_RETRIGGER, 1, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_CFG, tteg_pkg::REG_ATTACK, 0, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, -5, 5, NOTE_NONE, 1'b0},
    '{ROW_CFG, tteg_pkg::REG_MODE, TRIG_NONE, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_CFG, tteg_pkg::REG_DECAY, COEFF_MAX, 0, 0, NOTE_NONE, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, S_MAX, S_MIN, tteg_pkg::NOTE_ON, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, S_MIN, S_MAX, NOTE_NONE, 1'b0},
    '{ROW_FRAME, tteg_pkg::REG_THRESHOLD, 0, S_MAX, S_MIN, tteg_pkg::NOTE_OFF, 1'b1}
  };

  // Per-phase register choices for the random part
  logic [1:0] mode_by_phase [RANDOM_PHASES] = '{tteg_pkg::TRIG_AUDIO, tteg_pkg::TRIG_NOTE,
    tteg_pkg::TRIG_EITHER, tteg_pkg::TRIG_AUDIO, tteg_pkg::TRIG_EITHER, TRIG_NONE,
    tteg_pkg::TRIG_NOTE, tteg_pkg::TRIG_EITHER};
  logic [1:0] chan_by_phase [RANDOM_PHASES] = '{tteg_pkg::CH_STEREO, tteg_pkg::CH_MONO,
    tteg_pkg::CH_STEREO, CH_UNUSED0, tteg_pkg::CH_MONO, tteg_pkg::CH_STEREO, CH_UNUSED3,
    tteg_pkg::CH_MONO};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  sample_t     in_left_sample = '0;
  sample_t     in_right_sample = '0;
  logic [1:0]  in_note_event = NOTE_NONE;
  logic        in_silent = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  sample_t     out_left_out;
  sample_t     out_right_out;
  logic [23:0] out_envelope_out;
  logic [1:0]  out_phase_out;

  // Register copies seen by the predictor
  longint unsigned thr_reg = THR_RESET;
  longint unsigned attack_reg = ATTACK_RESET;
  longint unsigned decay_reg = DECAY_RESET;
  logic            retrig_reg = 1'b1;
  logic [1:0]      mode_reg = tteg_pkg::TRIG_AUDIO;
  logic [1:0]      chan_reg = tteg_pkg::CH_STEREO;

  // Envelope state of the predictor
  longint unsigned       env_level = 0;
  tteg_pkg::phase_code_t env_phase = tteg_pkg::PHASE_IDLE;
  logic                  note_held = 1'b0;
  logic                  prev_audio = 1'b0;
  logic                  prev_note = 1'b0;

  gate_result_t    pending_frames [$];
  int unsigned     mismatch_count = 0;
  longint unsigned cycle_count = 0;
  int unsigned     send_idle_pct = 0;
  int unsigned     stall_pct = 0;
  int unsigned     holdoff_asked = 0;
  int unsigned     holdoff_served = 0;
  int unsigned     holdoff_left = 0;
  int unsigned     burst_left = 0;

  threshold_triggered_envelope_gate_top #(
    .SAMPLE_BITS(SW),
    .COEFF_BITS(CW)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_left_sample(in_left_sample),
    .in_right_sample(in_right_sample),
    .in_note_event(in_note_event),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_left_out(out_left_out),
    .out_right_out(out_right_out),
    .out_envelope_out(out_envelope_out),
    .out_phase_out(out_phase_out)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  function automatic longint unsigned magnitude(input sample_t s);
    logic [SW-1:0] u;
    u = s[SW-1] ? -s : s;
    return u;
  endfunction

  // Scale a sample by the level, truncating the magnitude toward zero
  function automatic sample_t apply_gain(input sample_t s, input longint unsigned level);
    longint unsigned p;
    p = (magnitude(s) * level) >> tteg_pkg::ENV_FRAC;
    return s[SW-1] ? sample_t'(-p) : sample_t'(p);
  endfunction

  // Advance the envelope by one frame and return the scaled frame
  function automatic gate_result_t envelope_step(input sample_t l, input sample_t r,
                                                 input logic [1:0] ev);
    gate_result_t    res;
    logic            mono, audio, want, had, rise;
    longint unsigned ml, mr, ms, prod, dec;
    mono = (chan_reg == tteg_pkg::CH_MONO);
    if (ev == tteg_pkg::NOTE_ON) begin
      note_held = 1'b1;
    end else if (ev == tteg_pkg::NOTE_OFF) begin
      note_held = 1'b0;
    end
    ml = magnitude(l);
    mr = magnitude(r);
    ms = mono ? ml * ml : (ml * ml + mr * mr) >> 1;
    audio = (ms >= thr_reg);
    case (mode_reg)
      tteg_pkg::TRIG_AUDIO: begin
        want = audio;
        had = prev_audio;
      end
      tteg_pkg::TRIG_NOTE: begin
        want = note_held;
        had = prev_note;
      end
      tteg_pkg::TRIG_EITHER: begin
        want = audio || note_held;
        had = prev_audio || prev_note;
      end
      default: begin
        want = 1'b0;
        had = 1'b0;
      end
    endcase
    rise = want && !had;
    // A rising trigger outside decay always starts attack
    if (rise && env_phase != tteg_pkg::PHASE_DECAY) env_phase = tteg_pkg::PHASE_ATTACK;
    case (env_phase)
      tteg_pkg::PHASE_ATTACK: begin
        env_level += (attack_reg * (LEVEL_ONE - env_level)) >> CW;
        if (env_level >= tteg_pkg::ENV_PEAK || !want) env_phase = tteg_pkg::PHASE_DECAY;
      end
      tteg_pkg::PHASE_DECAY: begin
        // Round the decrement up so the level keeps falling
        prod = decay_reg * env_level;
        dec = (prod >> CW) + (((prod & 64'hFFFF) != 0) ? 64'd1 : 64'd0);
        env_level = (dec > env_level) ? 0 : env_level - dec;
        if (env_level <= tteg_pkg::ENV_FLOOR) begin
          env_level = 0;
          env_phase = tteg_pkg::PHASE_IDLE;
        end
        if (retrig_reg && rise) env_phase = tteg_pkg::PHASE_ATTACK;
      end
      default: begin
        env_phase = tteg_pkg::PHASE_IDLE;
        env_level = 0;
      end
    endcase
    res.left = apply_gain(l, env_level);
    res.right = mono ? sample_t'(0) : apply_gain(r, env_level);
    res.env = env_level[23:0];
    res.phase = env_phase;
    prev_audio = audio;
    prev_note = note_held;
    return res;
  endfunction

  // Track register writes, predict accepted frames, score results
  always @(posedge clk) begin
    gate_result_t exp_res;
    if (rst_n) begin
      if (cfg_wr_en) begin
        case (cfg_index)
          tteg_pkg::REG_THRESHOLD: thr_reg = cfg_data;
          tteg_pkg::REG_ATTACK:    attack_reg = cfg_data[CW-1:0];
          tteg_pkg::REG_DECAY:     decay_reg = cfg_data[CW-1:0];
          tteg_pkg::REG_RETRIGGER: retrig_reg = cfg_data[0];
          tteg_pkg::REG_MODE:      mode_reg = cfg_data[1:0];
          tteg_pkg::REG_CHANNELS:  chan_reg = cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        exp_res = envelope_step(in_left_sample, in_right_sample, in_note_event);
        if (in_silent) begin
          exp_res = '{left: '0, right: '0, env: '0, phase: tteg_pkg::PHASE_IDLE};
        end
        pending_frames.push_back(exp_res);
      end
      if (out_valid && out_ready) begin
        if (pending_frames.size() == 0) begin
          $error("result with no request outstanding");
          mismatch_count++;
        end else begin
          exp_res = pending_frames.pop_front();
          if (out_left_out !== exp_res.left) begin
            $error("left_out: expected %0d, got %0d", exp_res.left, out_left_out);
            mismatch_count++;
          end
          if (out_right_out !== exp_res.right) begin
            $error("right_out: expected %0d, got %0d", exp_res.right, out_right_out);
            mismatch_count++;
          end
          if (out_envelope_out !== exp_res.env) begin
            $error("envelope_out: expected %0d, got %0d", exp_res.env, out_envelope_out);
            mismatch_count++;
          end
          if (out_phase_out !== exp_res.phase) begin
            $error("phase_out: expected %0d, got %0d", exp_res.phase, out_phase_out);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Drive result ready: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (holdoff_asked != holdoff_served) begin
      holdoff_served = holdoff_asked;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one request and hold it until accepted, then idle at random
  task automatic send_frame(input sample_t l, input sample_t r, input logic [1:0] ev,
                            input logic silent);
    in_valid <= 1'b1;
    in_left_sample <= l;
    in_right_sample <= r;
    in_note_event <= ev;
    in_silent <= silent;
    do @(posedge clk); while (!in_ready);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop valid, let the last request reach the scoreboard, wait for every
  // outstanding result, then pause
  task automatic settle(input int unsigned pause);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (pause) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input longint unsigned val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic sample_t loud_sample();
    int m;
    m = $urandom_range(1 << 22, (1 << 23) - 1);
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      default: return $urandom_range(0, 1) ? sample_t'(m) : sample_t'(-m);
    endcase
  endfunction

  // Loud bursts framed by note on/off over a quiet floor, with some noise
  task automatic next_frame(output sample_t l, output sample_t r, output logic [1:0] ev);
    ev = NOTE_NONE;
    if (burst_left == 0 && $urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(1, 24);
      ev = tteg_pkg::NOTE_ON;
    end
    if (burst_left != 0) begin
      l = loud_sample();
      r = loud_sample();
      burst_left--;
      if (burst_left == 0 && $urandom_range(0, 1) == 1) ev = tteg_pkg::NOTE_OFF;
    end else begin
      l = sample_t'(int'($urandom_range(0, 8191)) - 4096);
      r = sample_t'(int'($urandom_range(0, 8191)) - 4096);
    end
    if ($urandom_range(0, 15) == 0) l = sample_t'($urandom());
    if ($urandom_range(0, 15) == 0) r = sample_t'($urandom());
    if ($urandom_range(0, 19) == 0) ev = 2'($urandom_range(0, 3));
  endtask

  // Load all six registers for one random phase
  task automatic randomize_regs(input int unsigned ph);
    longint unsigned amp, thr, atk, dcy;
    amp = $urandom_range(1 << 20, 1 << 22);
    thr = amp * amp;
    atk = $urandom_range(2000, 65535);
    dcy = $urandom_range(8000, 65535);
    case (ph)
      1: thr = 0;
      3: begin
        atk = 1;
        dcy = 0;
      end
      4: begin
        atk = COEFF_MAX;
        dcy = COEFF_MAX;
      end
      6: thr = THR_FULL;
      7: thr = {$urandom(), $urandom()} & ((64'd1 << CFG_W) - 1);
      default: ;
    endcase
    write_reg(tteg_pkg::REG_THRESHOLD, thr);
    write_reg(tteg_pkg::REG_ATTACK, atk);
    write_reg(tteg_pkg::REG_DECAY, dcy);
    write_reg(tteg_pkg::REG_RETRIGGER, $urandom_range(0, 1));
    write_reg(tteg_pkg::REG_MODE, mode_by_phase[ph]);
    write_reg(tteg_pkg::REG_CHANNELS, chan_by_phase[ph]);
  endtask

  initial begin
    sample_t    l, r;
    logic [1:0] ev;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle(DRAIN_CYCLES);
        write_reg(directed_rows[i].idx, directed_rows[i].val);
      end else begin
        send_frame(directed_rows[i].left, directed_rows[i].right, directed_rows[i].note,
                   directed_rows[i].silent);
      end
    end

    // Random phases, cycling through the idle patterns
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle(DRAIN_CYCLES);
      randomize_regs(ph);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 61;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 61;
        end
        default: begin
          send_idle_pct = 29;
          stall_pct = 29;
        end
      endcase
      // Back up the block with a long receiver hold-off
      if (ph == 0) holdoff_asked <= holdoff_asked + 1;
      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        // Hold the sender until everything in flight has come back
        if (ph == 5 && n == FRAMES_PER_PHASE / 2) settle(0);
        next_frame(l, r, ev);
        send_frame(l, r, ev, 1'b0);
      end
    end

    settle(DRAIN_CYCLES);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
